// File: rtl/core/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types, constants and the control store of the three-wire serial
// bus master.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

  // Configuration register indexes and reset values.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_BIT_HOLD  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_HOLD = 2'd1;
  localparam logic [7:0] BIT_HOLD_RST  = 8'd14;
  localparam logic [7:0] EDGE_HOLD_RST = 8'd2;

  // Index of the most significant bit of a byte, where each byte starts.
  localparam logic [2:0] BIT_IDX_MSB = 3'd7;

  // Input beat: one byte to move.
  typedef struct packed {
    logic       operation;
    logic [7:0] tx_byte;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] line_samples;
  } tws_in_t;

  // Result beat: one pin state.
  typedef struct packed {
    logic       cs_level;
    logic       sck_level;
    logic       sio_drive;
    logic       sio_level;
    logic [7:0] hold_ticks;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       last_result;
  } tws_out_t;

  // Microprogram step addresses.
  typedef enum logic [2:0] {
    STEP_CS_PRE   = 3'd0,
    STEP_CS_RAISE = 3'd1,
    STEP_BIT_LO   = 3'd2,
    STEP_BIT_HI   = 3'd3,
    STEP_TAIL     = 3'd4,
    STEP_CS_DROP  = 3'd5
  } tws_step_t;

  // Sources for the data line drive enable.
  typedef enum logic [1:0] {
    DRV_ONE  = 2'd0,
    DRV_OP   = 2'd1,
    DRV_ZERO = 2'd2
  } tws_drv_src_t;

  // Sources for the data line level.
  typedef enum logic [1:0] {
    LVL_ONE  = 2'd0,
    LVL_DATA = 2'd1,
    LVL_ZERO = 2'd2
  } tws_lvl_src_t;

  // Which hold register times the pin state.
  typedef enum logic {
    HOLD_EDGE = 1'b0,
    HOLD_BIT  = 1'b1
  } tws_hold_src_t;

  // Sequencing after a step.
  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_BIT_LOOP = 2'd1,
    JMP_END      = 2'd2
  } tws_jump_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic          cs;
    logic          sck;
    tws_drv_src_t  drv_src;
    tws_lvl_src_t  lvl_src;
    tws_hold_src_t hold_src;
    logic          rx_chk;
    tws_jump_t     jump;
  } tws_word_t;

  // Sequencer to datapath controls.
  typedef struct packed {
    logic      fire;
    logic      final_beat;
    logic      idx_dec;
    tws_word_t word;
  } tws_ctl_t;

  // Datapath to sequencer status.
  typedef struct packed {
    logic slot_free;
    logic idx_zero;
    logic last_byte;
  } tws_stat_t;

  // Control store. Unused addresses decode as the chip select drop, which ends.
  function automatic tws_word_t tws_rom(input tws_step_t step);
    tws_word_t w;
    unique case (step)
      STEP_CS_PRE:   w = '{1'b0, 1'b1, DRV_ONE,  LVL_ONE,  HOLD_EDGE, 1'b0, JMP_NEXT};
      STEP_CS_RAISE: w = '{1'b1, 1'b1, DRV_ONE,  LVL_ONE,  HOLD_EDGE, 1'b0, JMP_NEXT};
      STEP_BIT_LO:   w = '{1'b1, 1'b0, DRV_OP,   LVL_DATA, HOLD_BIT,  1'b0, JMP_NEXT};
      STEP_BIT_HI:   w = '{1'b1, 1'b1, DRV_OP,   LVL_DATA, HOLD_BIT,  1'b1, JMP_BIT_LOOP};
      STEP_TAIL:     w = '{1'b1, 1'b1, DRV_OP,   LVL_DATA, HOLD_EDGE, 1'b0, JMP_NEXT};
      STEP_CS_DROP:  w = '{1'b0, 1'b1, DRV_ZERO, LVL_ZERO, HOLD_EDGE, 1'b0, JMP_END};
      default:       w = '{1'b0, 1'b1, DRV_ZERO, LVL_ZERO, HOLD_EDGE, 1'b0, JMP_END};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tws_sequencer.sv
// ----------------------------------------------------------------------------
// tws_sequencer
// Step counter over the control store, with the bit loop and end jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_sequencer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              first,
  input  tws_pkg::tws_stat_t     stat,
  output tws_pkg::tws_ctl_t      ctl,
  output logic                   busy
);

  tws_pkg::tws_step_t step_r, step_nxt;
  logic               busy_r, busy_nxt;
  tws_pkg::tws_word_t word;
  logic               fire;
  logic               finish;
  logic               loop_back;

  // Control word for the current step.
  assign word = tws_pkg::tws_rom(step_r);
  assign fire = busy_r & stat.slot_free;

  // Jump conditions.
  always_comb begin
    loop_back = (word.jump == tws_pkg::JMP_BIT_LOOP) & ~stat.idx_zero;
    finish    = (word.jump == tws_pkg::JMP_END) |
                ((word.jump == tws_pkg::JMP_BIT_LOOP) & stat.idx_zero & ~stat.last_byte);
  end

  // Next step and busy flag.
  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      step_nxt = first ? tws_pkg::STEP_CS_PRE : tws_pkg::STEP_BIT_LO;
      busy_nxt = 1'b1;
    end else if (fire) begin
      if (loop_back) begin
        step_nxt = tws_pkg::STEP_BIT_LO;
      end else begin
        step_nxt = tws_pkg::tws_step_t'(step_r + 3'd1);
      end
      if (finish) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Outputs to the datapath.
  always_comb begin
    ctl.fire       = fire;
    ctl.final_beat = finish;
    ctl.idx_dec    = fire & loop_back;
    ctl.word       = word;
    busy           = busy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tws_pkg::STEP_CS_PRE;
      busy_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tws_datapath.sv
// ----------------------------------------------------------------------------
// tws_datapath
// Item registers, bit index, hold registers and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  tws_pkg::tws_in_t                   in_data,
  input  tws_pkg::tws_ctl_t                  ctl,
  input  wire logic                          cfg_we,
  input  wire logic [tws_pkg::CfgIdxW-1:0]   cfg_idx,
  input  wire logic [7:0]                    cfg_wdata,
  input  wire logic                          out_ready,
  output tws_pkg::tws_stat_t                 stat,
  output logic                               out_valid,
  output tws_pkg::tws_out_t                  out_data
);

  logic             op_r;
  logic [7:0]       tx_r;
  logic             last_r;
  logic [7:0]       samples_r;
  logic [2:0]       idx_r, idx_nxt;
  logic [7:0]       bit_hold_r, bit_hold_nxt;
  logic [7:0]       edge_hold_r, edge_hold_nxt;
  logic             out_valid_r, out_valid_nxt;
  tws_pkg::tws_out_t out_data_r, beat;
  logic             rx_hit;

  // Status back to the sequencer.
  always_comb begin
    stat.slot_free = ~out_valid_r | out_ready;
    stat.idx_zero  = (idx_r == 3'd0);
    stat.last_byte = last_r;
  end

  // Build the pin state selected by the control word.
  always_comb begin
    rx_hit = ctl.word.rx_chk & op_r & (idx_r == 3'd0);
    beat.cs_level  = ctl.word.cs;
    beat.sck_level = ctl.word.sck;
    unique case (ctl.word.drv_src)
      tws_pkg::DRV_ONE: beat.sio_drive = 1'b1;
      tws_pkg::DRV_OP:  beat.sio_drive = ~op_r;
      default:          beat.sio_drive = 1'b0;
    endcase
    unique case (ctl.word.lvl_src)
      tws_pkg::LVL_ONE:  beat.sio_level = 1'b1;
      tws_pkg::LVL_DATA: beat.sio_level = ~op_r & tx_r[idx_r];
      default:           beat.sio_level = 1'b0;
    endcase
    beat.hold_ticks  = (ctl.word.hold_src == tws_pkg::HOLD_BIT) ? bit_hold_r : edge_hold_r;
    beat.rx_byte     = rx_hit ? samples_r : 8'd0;
    beat.rx_valid    = rx_hit;
    beat.last_result = ctl.final_beat;
  end

  // Next values of the bit index, configuration and output valid.
  always_comb begin
    idx_nxt = idx_r;
    if (start) begin
      idx_nxt = tws_pkg::BIT_IDX_MSB;
    end else if (ctl.idx_dec) begin
      idx_nxt = idx_r - 3'd1;
    end
    bit_hold_nxt  = bit_hold_r;
    edge_hold_nxt = edge_hold_r;
    if (cfg_we && cfg_idx == tws_pkg::CFG_BIT_HOLD) begin
      bit_hold_nxt = cfg_wdata;
    end
    if (cfg_we && cfg_idx == tws_pkg::CFG_EDGE_HOLD) begin
      edge_hold_nxt = cfg_wdata;
    end
    out_valid_nxt = out_valid_r;
    if (ctl.fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_hold_r  <= tws_pkg::BIT_HOLD_RST;
      edge_hold_r <= tws_pkg::EDGE_HOLD_RST;
      out_valid_r <= 1'b0;
      idx_r       <= tws_pkg::BIT_IDX_MSB;
    end else begin
      bit_hold_r  <= bit_hold_nxt;
      edge_hold_r <= edge_hold_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Payload registers: the captured item and the result beat.
  always_ff @(posedge clk) begin
    if (start) begin
      op_r      <= in_data.operation;
      tx_r      <= in_data.tx_byte;
      last_r    <= in_data.last_byte;
      samples_r <= in_data.line_samples;
    end
    if (ctl.fire) begin
      out_data_r <= beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/core/three_wire_serial_master.sv
// ----------------------------------------------------------------------------
// three_wire_serial_master
// Three-wire serial bus master that turns byte requests into pin states.
// ----------------------------------------------------------------------------
// Each byte's first pin state goes through the step register and then the result register.
// Throughput: one pin state per cycle from the step counter while the result side
// accepts them; a byte yields 16 to 20 states.
// The next byte is taken once the sequencer has issued the last state of this one.
// Reset: synchronous, active low; hold registers return to 14 and 2, nothing pending.
`default_nettype none

module three_wire_serial_master (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  tws_pkg::tws_in_t                   in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output tws_pkg::tws_out_t                  out_data,
  input  wire logic                          cfg_we,
  input  wire logic [tws_pkg::CfgIdxW-1:0]   cfg_idx,
  input  wire logic [7:0]                    cfg_wdata
);

  tws_pkg::tws_ctl_t  ctl;
  tws_pkg::tws_stat_t stat;
  logic               busy;
  logic               start;

  // Input beat accepted whenever the sequencer is free.
  assign in_ready = ~busy;
  assign start    = in_valid & in_ready;

  tws_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .first (in_data.first_byte),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  tws_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .ctl       (ctl),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Read data only appears on a clock-high state with chip select raised.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_valid |-> out_data.cs_level && out_data.sck_level)
    else $error("rx_valid outside a clock-high state");

  // The chip select drop state always closes its byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.cs_level && !out_data.sio_drive |-> out_data.last_result)
    else $error("chip select drop not marked last");

  // An accepted byte keeps the sequencer busy in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a byte is in progress");

endmodule

`default_nettype wire
